### rtl/core/dcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcbd_pkg;

   // widths of the stream and arithmetic
   localparam int MAX_FIELD_BITS = 24;
   localparam int MIN_FIELD_BITS = 2;
   localparam int ACC_W          = 32;
   localparam int BUF_W          = 64;
   localparam int BUF_IDX_W      = $clog2(BUF_W);
   localparam int COUNT_W        = 7;
   localparam int WIDTH_W        = 6;
   localparam int SKIP_W         = 4;
   localparam int BYTE_W         = 8;
   localparam int START_CAP      = 56;

   // pairs one byte may produce before decoding pauses
   localparam int MAX_RESULTS    = 4;
   localparam int PAIR_CNT_W     = 3;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_X_WIDTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_WIDTH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_EXTRA_BIT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_X_SIGNED    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_X_NEGATE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_SIGNED    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_NEGATE    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_SKIP = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } dcbd_req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] x_delta;
      logic signed [ACC_W-1:0] y_delta;
      logic                    run_last;
   } dcbd_rsp_type;

   // decoded configuration, widths already clamped
   typedef struct packed {
      logic [WIDTH_W-1:0] x_width;
      logic [WIDTH_W-1:0] y_width;
      logic               extra_bit;
      logic               x_signed;
      logic               x_negate;
      logic               y_signed;
      logic               y_negate;
      logic [SKIP_W-1:0]  skip_bits;
   } dcbd_cfg_type;

   typedef struct packed {
      logic load;
      logic drop_skip;
      logic start_pair;
      logic read_field;
      logic sel_y;
      logic capture;
      logic push;
      logic push_last;
      logic clear;
   } dcbd_cmd_type;

   typedef struct packed {
      logic ge_skip;
      logic ge_need;
      logic field_avail;
      logic field_done;
      logic pend_valid;
      logic out_free;
   } dcbd_status_type;

endpackage

`default_nettype wire

### rtl/core/delta_coordinate_bitstream_decoder_core.sv
// delta coordinate bitstream decoder
// request channel: req_valid / req_stall / req_data carry one stream byte,
//   used least significant bit first, with last_byte marking the final byte
// response channel: rsp_valid / rsp_stall / rsp_data carry one (x, y) delta
//   pair; run_last flags the last pair produced by a request
// csr channel: csr_valid / csr_ready / csr_index / csr_wdata write the
//   field widths, sign modes, extra bit and header skip; csr_ready is always
//   high, write only while the block is idle
// decode steps: a request loads its byte, then walks the header skip, a pair
//   start and one field per coordinate, with an extra field per escape; a
//   pair is held until the next pair completes or the byte runs out, then
//   moves to the output register
// throughput: one request at a time, set by the single shared field
//   extractor, which reads one field per cycle while no stall holds it
// reset: synchronous, clears the buffer, accumulators and sign/width setup
//   to their defaults; after a last_byte request the stream restarts alike
// stall: the output register holds while rsp_stall is high; decoding goes on
//   until a second pair is ready, then waits for the register to drain
`timescale 1ns / 1ps
`default_nettype none

module delta_coordinate_bitstream_decoder_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire dcbd_pkg::dcbd_req_type           req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output dcbd_pkg::dcbd_rsp_type                rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dcbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dcbd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dcbd_pkg::*;

   // raw register file
   logic [CSR_DATA_W-1:0] x_width_ff, x_width_in;
   logic [CSR_DATA_W-1:0] y_width_ff, y_width_in;
   logic                  extra_bit_ff, extra_bit_in;
   logic                  x_signed_ff, x_signed_in;
   logic                  x_negate_ff, x_negate_in;
   logic                  y_signed_ff, y_signed_in;
   logic                  y_negate_ff, y_negate_in;
   logic [SKIP_W-1:0]     skip_ff, skip_in;

   dcbd_cfg_type    cfg;
   dcbd_cmd_type    cmd;
   dcbd_status_type st;

   logic [WIDTH_W-1:0] xw_raw;
   logic [WIDTH_W-1:0] yw_raw;

   assign csr_ready = 1'b1;

   always_comb begin
      x_width_in   = x_width_ff;
      y_width_in   = y_width_ff;
      extra_bit_in = extra_bit_ff;
      x_signed_in  = x_signed_ff;
      x_negate_in  = x_negate_ff;
      y_signed_in  = y_signed_ff;
      y_negate_in  = y_negate_ff;
      skip_in      = skip_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_X_WIDTH:     x_width_in   = csr_wdata;
            REG_Y_WIDTH:     y_width_in   = csr_wdata;
            REG_EXTRA_BIT:   extra_bit_in = csr_wdata[0];
            REG_X_SIGNED:    x_signed_in  = csr_wdata[0];
            REG_X_NEGATE:    x_negate_in  = csr_wdata[0];
            REG_Y_SIGNED:    y_signed_in  = csr_wdata[0];
            REG_Y_NEGATE:    y_negate_in  = csr_wdata[0];
            REG_HEADER_SKIP: skip_in      = csr_wdata[SKIP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_width_ff   <= CSR_DATA_W'(MIN_FIELD_BITS);
         y_width_ff   <= CSR_DATA_W'(MIN_FIELD_BITS);
         extra_bit_ff <= 1'b0;
         x_signed_ff  <= 1'b0;
         x_negate_ff  <= 1'b0;
         y_signed_ff  <= 1'b0;
         y_negate_ff  <= 1'b0;
         skip_ff      <= SKIP_W'(2);
      end else begin
         x_width_ff   <= x_width_in;
         y_width_ff   <= y_width_in;
         extra_bit_ff <= extra_bit_in;
         x_signed_ff  <= x_signed_in;
         x_negate_ff  <= x_negate_in;
         y_signed_ff  <= y_signed_in;
         y_negate_ff  <= y_negate_in;
         skip_ff      <= skip_in;
      end
   end

   // widths outside the legal range saturate at the nearest limit
   always_comb begin
      xw_raw = WIDTH_W'(x_width_ff);
      yw_raw = WIDTH_W'(y_width_ff);
      cfg.x_width = (xw_raw < WIDTH_W'(MIN_FIELD_BITS)) ? WIDTH_W'(MIN_FIELD_BITS) :
                    (xw_raw > WIDTH_W'(MAX_FIELD_BITS)) ? WIDTH_W'(MAX_FIELD_BITS) : xw_raw;
      cfg.y_width = (yw_raw < WIDTH_W'(MIN_FIELD_BITS)) ? WIDTH_W'(MIN_FIELD_BITS) :
                    (yw_raw > WIDTH_W'(MAX_FIELD_BITS)) ? WIDTH_W'(MAX_FIELD_BITS) : yw_raw;
      cfg.extra_bit = extra_bit_ff;
      cfg.x_signed  = x_signed_ff;
      cfg.x_negate  = x_negate_ff;
      cfg.y_signed  = y_signed_ff;
      cfg.y_negate  = y_negate_ff;
      cfg.skip_bits = skip_ff;
   end

   // sequencer: walks header, pair start, x and y fields
   dcbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_last  (req_data.last_byte),
      .st        (st),
      .cmd       (cmd)
   );

   // bit buffer, field extractor, accumulators, pending pair, output register
   dcbd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .st        (st),
      .req_byte  (req_data.data_byte),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/core/dcbd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dcbd_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dcbd_pkg::dcbd_cfg_type   cfg,
   input  wire dcbd_pkg::dcbd_cmd_type   cmd,
   output dcbd_pkg::dcbd_status_type     st,
   input  wire logic [dcbd_pkg::BYTE_W-1:0] req_byte,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output dcbd_pkg::dcbd_rsp_type        rsp_data
);
   import dcbd_pkg::*;

   logic [BUF_W-1:0]   bits_ff, bits_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ACC_W-1:0]   xacc_ff, xacc_in;
   logic [ACC_W-1:0]   yacc_ff, yacc_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [ACC_W-1:0]   pend_x_ff, pend_x_in;
   logic [ACC_W-1:0]   pend_y_ff, pend_y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dcbd_rsp_type       rsp_data_ff, rsp_data_in;

   // field extractor signals
   logic [WIDTH_W-1:0] fw;
   logic               fsgn;
   logic               fneg;
   logic [ACC_W-1:0]   facc;
   logic [ACC_W-1:0]   fmask;
   logic [ACC_W-1:0]   fsbit;
   logic [ACC_W-1:0]   fsbit2;
   logic [ACC_W-1:0]   fval;
   logic               fesc;
   logic [ACC_W-1:0]   acc_new;

   logic [COUNT_W-1:0] need_sum;
   logic [COUNT_W-1:0] need;
   logic [WIDTH_W-1:0] drop_amt;
   logic               do_drop;

   always_comb begin
      fw    = cmd.sel_y ? cfg.y_width : cfg.x_width;
      fsgn  = cmd.sel_y ? cfg.y_signed : cfg.x_signed;
      fneg  = cmd.sel_y ? cfg.y_negate : cfg.x_negate;
      facc  = cmd.sel_y ? yacc_ff : xacc_ff;
      fmask = {ACC_W{1'b1}} >> (WIDTH_W'(ACC_W) - fw);
      fsbit = ACC_W'(1) << (fw - WIDTH_W'(1));
      fsbit2 = fsbit << 1;
      fval  = bits_ff[ACC_W-1:0] & fmask;
      fesc  = fsgn && (fval == fsbit);
      if (!fsgn) begin
         acc_new = fneg ? ('0 - fval) : fval;
      end else if (fesc) begin
         acc_new = facc + fval - ACC_W'(1);
      end else if (fval < fsbit) begin
         acc_new = facc + fval;
      end else begin
         acc_new = fval - fsbit2 - facc;
      end
   end

   always_comb begin
      need_sum = COUNT_W'(cfg.x_width) + COUNT_W'(cfg.y_width) + COUNT_W'(cfg.extra_bit);
      need     = (need_sum > COUNT_W'(START_CAP)) ? COUNT_W'(START_CAP) : need_sum;
   end

   always_comb begin
      st.ge_skip     = count_ff >= COUNT_W'(cfg.skip_bits);
      st.ge_need     = count_ff >= need;
      st.field_avail = count_ff >= COUNT_W'(fw);
      st.field_done  = !fesc;
      st.pend_valid  = pend_valid_ff;
      st.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      drop_amt = fw;
      if (cmd.drop_skip) begin
         drop_amt = WIDTH_W'(cfg.skip_bits);
      end else if (cmd.start_pair) begin
         drop_amt = WIDTH_W'(cfg.extra_bit);
      end
      do_drop = cmd.drop_skip || cmd.start_pair || cmd.read_field;
   end

   always_comb begin
      bits_in       = bits_ff;
      count_in      = count_ff;
      xacc_in       = xacc_ff;
      yacc_in       = yacc_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         bits_in  = bits_ff | (BUF_W'(req_byte) << count_ff[BUF_IDX_W-1:0]);
         count_in = count_ff + COUNT_W'(BYTE_W);
      end else if (do_drop) begin
         bits_in  = bits_ff >> drop_amt;
         count_in = (count_ff > COUNT_W'(drop_amt)) ? count_ff - COUNT_W'(drop_amt) : '0;
      end

      if (cmd.start_pair) begin
         xacc_in = '0;
         yacc_in = '0;
      end else if (cmd.read_field) begin
         if (cmd.sel_y) begin
            yacc_in = acc_new;
         end else begin
            xacc_in = acc_new;
         end
      end

      if (cmd.push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{x_delta: pend_x_ff, y_delta: pend_y_ff, run_last: cmd.push_last};
         pend_valid_in = 1'b0;
      end

      if (cmd.capture) begin
         pend_valid_in = 1'b1;
         pend_x_in     = xacc_ff;
         pend_y_in     = acc_new;
      end

      if (cmd.clear) begin
         bits_in  = '0;
         count_in = '0;
         xacc_in  = '0;
         yacc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff       <= '0;
         count_ff      <= '0;
         xacc_ff       <= '0;
         yacc_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bits_ff       <= bits_in;
         count_ff      <= count_in;
         xacc_ff       <= xacc_in;
         yacc_ff       <= yacc_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // a new byte always lands inside the buffer
   a_load_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> count_ff <= COUNT_W'(START_CAP - 1))
      else $error("byte loaded into a full buffer");

   // only a held pair is ever sent
   a_push_has_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> pend_valid_ff)
      else $error("push without a pending pair");

   // a stalled response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");
`endif

endmodule

`default_nettype wire

### rtl/core/dcbd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dcbd_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_last,
   input  wire dcbd_pkg::dcbd_status_type st,
   output dcbd_pkg::dcbd_cmd_type         cmd
);
   import dcbd_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_START  = 2'd1;
   localparam logic [1:0] PH_X      = 2'd2;
   localparam logic [1:0] PH_Y      = 2'd3;

   logic                  state_ff, state_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  last_ff, last_in;
   logic [PAIR_CNT_W-1:0] pairs_ff, pairs_in;
   logic                  brk;

   always_comb begin
      cmd       = '0;
      cmd.sel_y = (phase_ff == PH_Y);
      state_in  = state_ff;
      phase_in  = phase_ff;
      last_in   = last_ff;
      pairs_in  = pairs_ff;
      brk       = 1'b0;
      req_stall = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = req_last;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (pairs_ff == PAIR_CNT_W'(MAX_RESULTS)) begin
               // result limit for one byte reached: pause until the next one
               brk = 1'b1;
            end else begin
               unique case (phase_ff)
                  PH_HEADER: begin
                     if (st.ge_skip) begin
                        cmd.drop_skip = 1'b1;
                        phase_in      = PH_START;
                     end else begin
                        brk = 1'b1;
                     end
                  end
                  PH_START: begin
                     if (st.ge_need) begin
                        cmd.start_pair = 1'b1;
                        phase_in       = PH_X;
                     end else begin
                        brk = 1'b1;
                     end
                  end
                  PH_X: begin
                     if (st.field_avail || last_ff) begin
                        cmd.read_field = 1'b1;
                        if (st.field_done) begin
                           phase_in = PH_Y;
                        end
                     end else begin
                        brk = 1'b1;
                     end
                  end
                  PH_Y: begin
                     if (st.field_avail || last_ff) begin
                        // hold off while the previous pair cannot move out
                        if (!st.pend_valid || st.out_free) begin
                           cmd.read_field = 1'b1;
                           if (st.field_done) begin
                              cmd.capture = 1'b1;
                              cmd.push    = st.pend_valid;
                              phase_in    = PH_START;
                              pairs_in    = pairs_ff + PAIR_CNT_W'(1);
                           end
                        end
                     end else begin
                        brk = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = PH_HEADER;
                  end
               endcase
            end

            // byte used up or result limit hit: flush the held pair as the run's last one
            if (brk && (!st.pend_valid || st.out_free)) begin
               cmd.push      = st.pend_valid;
               cmd.push_last = 1'b1;
               state_in      = ST_IDLE;
               pairs_in      = '0;
               if (last_ff) begin
                  cmd.clear = 1'b1;
                  phase_in  = PH_HEADER;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_HEADER;
         last_ff  <= 1'b0;
         pairs_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
         pairs_ff <= pairs_in;
      end
   end

`ifndef SYNTH
   // nothing is left held back once a byte is finished
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !st.pend_valid)
      else $error("pending pair left at idle");

   // a pair is only sent when the output register can take it
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> st.out_free)
      else $error("push into a busy output register");

   // an accepted request always starts decoding
   a_accept_run: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_RUN)
      else $error("accepted request not decoded");
`endif

endmodule

`default_nettype wire

### verif/tb_delta_coordinate_bitstream_decoder_core.sv
`timescale 1ns / 1ps

module tb_delta_coordinate_bitstream_decoder_core;
   import dcbd_pkg::*;

   // timing of the run
   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 7;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int LIMIT_NS     = 5_000_000;

   // stimulus shape
   localparam int IDLE_PCT      = 18;
   localparam int RANDOM_BYTES  = 90;
   localparam int PRESSURE_LEN  = 12;
   localparam int QUIET_FIRST   = 35;
   localparam int QUIET_LAST    = 70;
   localparam int MAX_PAIRS     = 4;
   localparam int MAX_REPORTS   = 10;

   // decoder position within the stream
   typedef enum logic [1:0] {
      DP_HEADER,
      DP_PAIR,
      DP_X,
      DP_Y
   } dec_phase_type;

   typedef enum logic {
      ROW_CSR,
      ROW_BYTE
   } row_kind_type;

   // one line of the directed table; n_typed > 0 means the pairs are written out
   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   wdata;
      logic [BYTE_W-1:0]       data;
      logic                    last;
      logic [1:0]              n_typed;
      logic [1:0][ACC_W-1:0]   tx;
      logic [1:0][ACC_W-1:0]   ty;
   } stim_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   dcbd_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   dcbd_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // decoder state as the testbench sees it
   logic [BUF_W-1:0] bitbuf    = '0;
   int unsigned      bitcnt    = 0;
   dec_phase_type    dec_phase = DP_HEADER;
   logic [ACC_W-1:0] acc_x     = '0;
   logic [ACC_W-1:0] acc_y     = '0;

   // register copies, reset values
   logic [CSR_DATA_W-1:0] cfg_xw    = 5'd2;
   logic [CSR_DATA_W-1:0] cfg_yw    = 5'd2;
   logic                  cfg_extra = 1'b0;
   logic                  cfg_xsig  = 1'b0;
   logic                  cfg_xneg  = 1'b0;
   logic                  cfg_ysig  = 1'b0;
   logic                  cfg_yneg  = 1'b0;
   logic [SKIP_W-1:0]     cfg_skip  = 4'd2;

   dcbd_rsp_type pending_pairs[$];
   int           bad_pairs = 0;
   bit           no_idle   = 1'b0;
   bit           hold_req  = 1'b0;

   delta_coordinate_bitstream_decoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // out of range widths act as the nearest legal one
   function automatic int unsigned field_bits(input logic [CSR_DATA_W-1:0] w);
      if (w < MIN_FIELD_BITS) return MIN_FIELD_BITS;
      if (w > MAX_FIELD_BITS) return MAX_FIELD_BITS;
      return 32'(w);
   endfunction

   task automatic shift_out(input int unsigned n);
      bitbuf = bitbuf >> n;
      bitcnt = (bitcnt > n) ? bitcnt - n : 0;
   endtask

   // one field of a coordinate; done is low after an escape field
   task automatic take_field(input int unsigned w, input logic sgn, input logic neg,
                             inout logic [ACC_W-1:0] acc, output bit done);
      logic [ACC_W-1:0] f;
      logic [ACC_W-1:0] sbit;
      sbit = 32'd1 << (w - 1);
      f    = bitbuf[ACC_W-1:0] & ((32'd1 << w) - 32'd1);
      shift_out(w);
      done = 1'b1;
      if (!sgn) begin
         acc = neg ? (32'd0 - f) : f;
      end else if (f == sbit) begin
         // escape: add magnitude less one and read another field
         acc  = acc + f - 32'd1;
         done = 1'b0;
      end else if (f < sbit) begin
         acc = acc + f;
      end else begin
         acc = f - (sbit << 1) - acc;
      end
   endtask

   // feeds one stream byte and queues the pairs it completes
   task automatic decode_byte(input logic [BYTE_W-1:0] data, input logic last, input bit keep);
      dcbd_rsp_type found [MAX_PAIRS];
      int           n;
      int unsigned  xw;
      int unsigned  yw;
      int unsigned  need;
      bit           done;
      n      = 0;
      bitbuf = bitbuf | ({{(BUF_W-BYTE_W){1'b0}}, data} << bitcnt);
      bitcnt = bitcnt + BYTE_W;
      while (n < MAX_PAIRS) begin
         // widths read fresh at every step so late writes land on the next field
         xw = field_bits(cfg_xw);
         yw = field_bits(cfg_yw);
         if (dec_phase == DP_HEADER) begin
            if (bitcnt < cfg_skip) break;
            shift_out(32'(cfg_skip));
            dec_phase = DP_PAIR;
         end else if (dec_phase == DP_PAIR) begin
            need = xw + yw + cfg_extra;
            if (need > START_CAP) need = START_CAP;
            if (bitcnt < need) break;
            if (cfg_extra) shift_out(1);
            acc_x     = '0;
            acc_y     = '0;
            dec_phase = DP_X;
         end else if (dec_phase == DP_X) begin
            // at stream end a short field reads zeros above the buffered bits
            if (bitcnt < xw && !last) break;
            take_field(xw, cfg_xsig, cfg_xneg, acc_x, done);
            if (done) dec_phase = DP_Y;
         end else begin
            if (bitcnt < yw && !last) break;
            take_field(yw, cfg_ysig, cfg_yneg, acc_y, done);
            if (done) begin
               found[n].x_delta  = acc_x;
               found[n].y_delta  = acc_y;
               found[n].run_last = 1'b0;
               n++;
               dec_phase = DP_PAIR;
            end
         end
      end
      if (keep) begin
         for (int i = 0; i < n; i++) begin
            found[i].run_last = (i == n - 1);
            pending_pairs.push_back(found[i]);
         end
      end
      // stream end drops leftover bits and starts over
      if (last) begin
         bitbuf    = '0;
         bitcnt    = 0;
         dec_phase = DP_HEADER;
         acc_x     = '0;
         acc_y     = '0;
      end
   endtask

   // csr write; the caller lowers csr_valid after the last one
   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_X_WIDTH:     cfg_xw    = val;
         REG_Y_WIDTH:     cfg_yw    = val;
         REG_EXTRA_BIT:   cfg_extra = val[0];
         REG_X_SIGNED:    cfg_xsig  = val[0];
         REG_X_NEGATE:    cfg_xneg  = val[0];
         REG_Y_SIGNED:    cfg_ysig  = val[0];
         REG_Y_NEGATE:    cfg_yneg  = val[0];
         REG_HEADER_SKIP: cfg_skip  = val[SKIP_W-1:0];
         default: ;
      endcase
   endtask

   // offers one request with random gaps ahead of it, returns once accepted
   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last, input bit keep);
      csr_valid <= 1'b0;
      while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {data, last};
      do @(posedge clock); while (req_stall);
      decode_byte(data, last, keep);
   endtask

   // sender pause: every pair back, then time for a byte that yields none
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_width();
      // mostly narrow fields so pairs come often, now and then any code
      if ($urandom_range(99, 0) < 15) return CSR_DATA_W'($urandom_range(31, 0));
      return CSR_DATA_W'($urandom_range(6, 2));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_code();
      return CSR_DATA_W'($urandom_range(31, 0));
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.index = idx;
      r.wdata = val;
      return r;
   endfunction

   function automatic stim_row_type byte_row(input logic [BYTE_W-1:0] data, input logic last);
      stim_row_type r;
      r      = '0;
      r.kind = ROW_BYTE;
      r.data = data;
      r.last = last;
      return r;
   endfunction

   function automatic stim_row_type typed_row(input logic [BYTE_W-1:0] data, input logic last,
                                              input logic [1:0] n,
                                              input logic [ACC_W-1:0] x0, y0, x1, y1);
      stim_row_type r;
      r         = byte_row(data, last);
      r.n_typed = n;
      r.tx[0]   = x0;
      r.ty[0]   = y0;
      r.tx[1]   = x1;
      r.ty[1]   = y1;
      return r;
   endfunction

   // receiver: random stall, or one long hold when asked
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= !no_idle && ($urandom_range(99, 0) < IDLE_PCT);
      end
   end

   // compare each accepted pair with the oldest one predicted
   always @(posedge clock) begin : pair_check
      dcbd_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pairs.size() == 0) begin
            if (bad_pairs < MAX_REPORTS)
               $display("unexpected pair x=%0d y=%0d last=%0b",
                        rsp_data.x_delta, rsp_data.y_delta, rsp_data.run_last);
            bad_pairs++;
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_data.x_delta !== want.x_delta || rsp_data.y_delta !== want.y_delta ||
                rsp_data.run_last !== want.run_last) begin
               if (bad_pairs < MAX_REPORTS)
                  $display({"pair mismatch: expected x=%0d y=%0d last=%0b, ",
                            "got x=%0d y=%0d last=%0b"},
                           want.x_delta, want.y_delta, want.run_last,
                           rsp_data.x_delta, rsp_data.y_delta, rsp_data.run_last);
               bad_pairs++;
            end
         end
      end
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      stim_row_type dir_tab[$];
      dcbd_rsp_type p;
      int           sent;
      int           len;

      // after reset: skip two header bits, two-bit unsigned fields
      dir_tab.push_back(typed_row(8'hE4, 1'b0, 2'd1, 1, 2, 0, 0));
      dir_tab.push_back(typed_row(8'h1B, 1'b1, 2'd2, 3, 3, 2, 1));
      // negated unsigned fields, no header, two pairs from one byte
      dir_tab.push_back(csr_row(REG_X_NEGATE, 5'd1));
      dir_tab.push_back(csr_row(REG_Y_NEGATE, 5'd1));
      dir_tab.push_back(csr_row(REG_HEADER_SKIP, 5'd0));
      dir_tab.push_back(typed_row(8'hFF, 1'b1, 2'd2, -3, -3, -3, -3));
      // signed fields: escape runs, negative ends, short field at stream end
      dir_tab.push_back(csr_row(REG_X_NEGATE, 5'd0));
      dir_tab.push_back(csr_row(REG_Y_NEGATE, 5'd0));
      dir_tab.push_back(csr_row(REG_X_SIGNED, 5'd1));
      dir_tab.push_back(csr_row(REG_Y_SIGNED, 5'd1));
      dir_tab.push_back(byte_row(8'h9A, 1'b0));
      dir_tab.push_back(byte_row(8'h03, 1'b1));
      dir_tab.push_back(byte_row(8'hB7, 1'b1));
      // widest fields, extra bit, longest header, fields split over bytes
      dir_tab.push_back(csr_row(REG_X_WIDTH, 5'd24));
      dir_tab.push_back(csr_row(REG_Y_WIDTH, 5'd24));
      dir_tab.push_back(csr_row(REG_EXTRA_BIT, 5'd1));
      dir_tab.push_back(csr_row(REG_X_NEGATE, 5'd1));
      dir_tab.push_back(csr_row(REG_Y_NEGATE, 5'd1));
      dir_tab.push_back(csr_row(REG_HEADER_SKIP, 5'd15));
      dir_tab.push_back(byte_row(8'hFF, 1'b0));
      dir_tab.push_back(byte_row(8'hFF, 1'b0));
      dir_tab.push_back(byte_row(8'h7F, 1'b0));
      dir_tab.push_back(byte_row(8'h80, 1'b0));
      dir_tab.push_back(byte_row(8'h00, 1'b0));
      dir_tab.push_back(byte_row(8'h00, 1'b0));
      dir_tab.push_back(byte_row(8'h80, 1'b0));
      dir_tab.push_back(byte_row(8'h55, 1'b0));
      dir_tab.push_back(byte_row(8'hAA, 1'b1));
      // width codes below and above the legal range
      dir_tab.push_back(csr_row(REG_X_WIDTH, 5'd0));
      dir_tab.push_back(csr_row(REG_Y_WIDTH, 5'd31));
      dir_tab.push_back(csr_row(REG_EXTRA_BIT, 5'd0));
      dir_tab.push_back(csr_row(REG_X_SIGNED, 5'd0));
      dir_tab.push_back(csr_row(REG_Y_SIGNED, 5'd0));
      dir_tab.push_back(csr_row(REG_HEADER_SKIP, 5'd0));
      dir_tab.push_back(byte_row(8'h01, 1'b0));
      dir_tab.push_back(byte_row(8'h23, 1'b0));
      dir_tab.push_back(byte_row(8'h45, 1'b0));
      dir_tab.push_back(byte_row(8'h67, 1'b1));
      // setup changed while a stream is half way through
      dir_tab.push_back(csr_row(REG_X_WIDTH, 5'd3));
      dir_tab.push_back(csr_row(REG_Y_WIDTH, 5'd3));
      dir_tab.push_back(csr_row(REG_HEADER_SKIP, 5'd3));
      dir_tab.push_back(byte_row(8'h5A, 1'b0));
      dir_tab.push_back(csr_row(REG_X_SIGNED, 5'd1));
      dir_tab.push_back(csr_row(REG_Y_WIDTH, 5'd5));
      dir_tab.push_back(byte_row(8'hC4, 1'b1));
      // stream ends before the header is used up
      dir_tab.push_back(csr_row(REG_HEADER_SKIP, 5'd15));
      dir_tab.push_back(byte_row(8'hFF, 1'b1));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            if (i > 0 && dir_tab[i-1].kind == ROW_BYTE) settle();
            set_reg(dir_tab[i].index, dir_tab[i].wdata);
         end else begin
            send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].n_typed == 0);
            for (int k = 0; k < dir_tab[i].n_typed; k++) begin
               p.x_delta  = dir_tab[i].tx[k];
               p.y_delta  = dir_tab[i].ty[k];
               p.run_last = (k == dir_tab[i].n_typed - 1);
               pending_pairs.push_back(p);
            end
         end
      end

      // back pressure: two pairs per byte while the receiver holds off
      settle();
      set_reg(REG_X_WIDTH, 5'd2);
      set_reg(REG_Y_WIDTH, 5'd2);
      set_reg(REG_EXTRA_BIT, 5'd0);
      set_reg(REG_X_SIGNED, 5'd0);
      set_reg(REG_Y_SIGNED, 5'd0);
      set_reg(REG_HEADER_SKIP, 5'd0);
      hold_req = 1'b1;
      for (int k = 0; k < PRESSURE_LEN; k++)
         send_byte(BYTE_W'($urandom_range(255, 0)), k == PRESSURE_LEN - 1, 1'b1);

      // random streams under random setups; a few end without a last byte
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         settle();
         set_reg(REG_X_WIDTH, pick_width());
         set_reg(REG_Y_WIDTH, pick_width());
         set_reg(REG_EXTRA_BIT, rand_code());
         set_reg(REG_X_SIGNED, rand_code());
         set_reg(REG_X_NEGATE, rand_code());
         set_reg(REG_Y_SIGNED, rand_code());
         set_reg(REG_Y_NEGATE, rand_code());
         set_reg(REG_HEADER_SKIP, rand_code());
         len = $urandom_range(8, 1);
         for (int k = 1; k <= len; k++) begin
            // a stretch with no gaps on either side
            no_idle = (sent >= QUIET_FIRST && sent < QUIET_LAST);
            send_byte(BYTE_W'($urandom_range(255, 0)),
                      (k == len) && ($urandom_range(9, 0) != 0), 1'b1);
            sent++;
         end
      end
      no_idle = 1'b0;

      settle();
      if (bad_pairs == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
